### hdl/abvd_pkg.sv
// Package for the attribute/bitmap video decoder.
// Types, action codes and frame constants; no dependencies.
package abvd_pkg;

    localparam int STORE_AW = 13;

    typedef enum logic [1:0] {
        ACT_WRITE  = 2'd0,
        ACT_BORDER = 2'd1,
        ACT_FRAME  = 2'd2,
        ACT_RENDER = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ATTR,
        ST_FORM
    } seq_state_t;

    localparam logic [STORE_AW-1:0] ATTR_BASE = 13'h1800;
    localparam logic [7:0] FIRST_PIC_LINE = 8'd32;
    localparam logic [7:0] LAST_PIC_LINE  = 8'd223;
    localparam logic [5:0] FIRST_PIC_CELL = 6'd4;
    localparam logic [5:0] LAST_PIC_CELL  = 6'd35;

    // sequencer -> pixel former
    typedef struct packed {
        logic       capture;       // store read data is the bitmap byte
        logic       load;          // form the cell and load the output register
        logic       border;        // cell lies in the border
        logic [2:0] border_colour;
        logic       flash_phase;   // flash counter bit 4
    } form_ctrl_t;

endpackage

### hdl/abvd_if.sv
// Valid/ready channel interfaces for the decoder's input and result beats.
// Depends on nothing.
interface abvd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [12:0] store_address;
    logic [7:0]  data_byte;
    logic [7:0]  line;
    logic [5:0]  cell_req;

    modport source (output valid, action, store_address, data_byte, line, cell_req,
                    input ready);
    modport sink (input valid, action, store_address, data_byte, line, cell_req,
                  output ready);
endinterface

interface abvd_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixels;

    modport source (output valid, pixels, input ready);
    modport sink (input valid, pixels, output ready);
endinterface

### hdl/abvd_store.sv
// Display store: 8192 x 8 synchronous RAM, one write and one read port.
// Read data is registered. Uses abvd_pkg.
module abvd_store
    import abvd_pkg::*;
(
    input  logic                clk,
    input  logic                wr_en,
    input  logic [STORE_AW-1:0] wr_addr,
    input  logic [7:0]          wr_data,
    input  logic                rd_en,
    input  logic [STORE_AW-1:0] rd_addr,
    output logic [7:0]          rd_data
);

    logic [7:0] mem [2**STORE_AW];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/abvd_seq.sv
// Sequencer: accepts input beats, executes write/border/frame actions,
// issues the bitmap and attribute reads of a render. Uses abvd_pkg, abvd_if.
module abvd_seq
    import abvd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    abvd_in_if.sink             item,
    input  logic                out_free,
    output logic                wr_en,
    output logic [STORE_AW-1:0] wr_addr,
    output logic [7:0]          wr_data,
    output logic                rd_en,
    output logic [STORE_AW-1:0] rd_addr,
    output form_ctrl_t          ctrl
);

    seq_state_t          state_reg, state_next;
    logic [2:0]          border_reg, border_next;
    logic [4:0]          flash_reg, flash_next;
    logic                bcell_reg, bcell_next;
    logic [STORE_AW-1:0] attr_addr_reg;

    logic                fire;
    logic                in_pic;
    logic [7:0]          yy;
    logic [4:0]          x;
    logic [STORE_AW-1:0] bm_addr;
    logic [STORE_AW-1:0] at_addr;
    action_t             act;

    assign act    = action_t'(item.action);
    assign in_pic = (item.line >= FIRST_PIC_LINE) && (item.line <= LAST_PIC_LINE) &&
                    (item.cell_req >= FIRST_PIC_CELL) && (item.cell_req <= LAST_PIC_CELL);
    assign yy     = item.line - FIRST_PIC_LINE;
    assign x      = 5'(item.cell_req - FIRST_PIC_CELL);
    // interleaved thirds / pixel rows / character rows
    assign bm_addr = {yy[7:6], yy[2:0], yy[5:3], x};
    assign at_addr = ATTR_BASE | {3'b000, yy[7:3], x};

    // ready depends on state and output space only
    assign item.ready = (state_reg == ST_IDLE) || ((state_reg == ST_FORM) && out_free);

    assign fire    = item.valid && item.ready;
    assign wr_en   = fire && (act == ACT_WRITE);
    assign wr_addr = item.store_address;
    assign wr_data = item.data_byte;

    always_comb
    begin
        state_next  = state_reg;
        border_next = border_reg;
        flash_next  = flash_reg;
        bcell_next  = bcell_reg;
        rd_en       = 1'b0;
        rd_addr     = bm_addr;

        case (state_reg)
            ST_IDLE:
            begin
            end
            ST_ATTR:
            begin
                rd_en      = 1'b1;
                rd_addr    = attr_addr_reg;
                state_next = ST_FORM;
            end
            ST_FORM:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (fire)
        begin
            case (act)
                ACT_BORDER:
                begin
                    border_next = item.data_byte[2:0];
                end
                ACT_FRAME:
                begin
                    flash_next = flash_reg + 5'd1;
                end
                ACT_RENDER:
                begin
                    bcell_next = !in_pic;
                    if (in_pic)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = bm_addr;
                        state_next = ST_ATTR;
                    end
                    else
                    begin
                        state_next = ST_FORM;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            border_reg <= 3'd0;
            flash_reg  <= 5'd0;
            bcell_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            border_reg <= border_next;
            flash_reg  <= flash_next;
            bcell_reg  <= bcell_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            attr_addr_reg <= at_addr;
        end
    end

    assign ctrl.capture       = (state_reg == ST_ATTR);
    assign ctrl.load          = (state_reg == ST_FORM) && out_free;
    assign ctrl.border        = bcell_reg;
    assign ctrl.border_colour = border_reg;
    assign ctrl.flash_phase   = flash_reg[4];

endmodule

### hdl/abvd_pixel.sv
// Pixel former: holds the bitmap byte, expands bitmap + attribute into eight
// colour codes and drives the result register. Uses abvd_pkg, abvd_if.
module abvd_pixel
    import abvd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  form_ctrl_t ctrl,
    input  logic [7:0] rd_data,
    output logic       out_free,
    abvd_out_if.source result
);

    logic [7:0]  bits_reg;
    logic        valid_reg;
    logic [31:0] pixels_reg;
    logic [31:0] pixels_next;
    logic [2:0]  ink;
    logic [2:0]  paper;
    logic        swap;

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            bits_reg <= rd_data;
        end
    end

    // rd_data holds the attribute byte while the cell is formed
    assign swap  = rd_data[7] && ctrl.flash_phase;
    assign ink   = swap ? rd_data[5:3] : rd_data[2:0];
    assign paper = swap ? rd_data[2:0] : rd_data[5:3];

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            if (ctrl.border)
            begin
                pixels_next[4*i +: 4] = {1'b0, ctrl.border_colour};
            end
            else
            begin
                pixels_next[4*i +: 4] = {rd_data[6], bits_reg[i] ? ink : paper};
            end
        end
    end

    assign out_free = !valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            valid_reg <= ctrl.load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            pixels_reg <= pixels_next;
        end
    end

    assign result.valid  = valid_reg;
    assign result.pixels = pixels_reg;

endmodule

### hdl/attribute_bitmap_video_decode_top.sv
// Attribute/bitmap video decoder, top level.
// Depends on abvd_pkg, abvd_if, abvd_store, abvd_seq, abvd_pixel.
//
// Usage:
//   item   : input beats (valid/ready). action selects write store byte,
//            set border colour, new frame (flash counter +1) or render cell.
//   result : one 32-bit beat per render, eight 4-bit codes bright|index,
//            leftmost pixel in bits 31:28. Other actions give no beat.
// Sequencing:
//   Write, border and frame actions complete at the accepting edge; the
//   next beat may follow in the next cycle.
//   A picture render reads the bitmap byte (issued at the accepting edge)
//   and then the attribute byte over the single store read port, so its
//   result is loaded from the forming state once the output register is free.
//   Another render can be accepted in the cycle of that load, not earlier.
//   A border render goes straight to the forming state and is loaded likewise.
// Reset: rst_n (async, active low) clears the border colour, the flash
//   counter and all handshake state. The display store is not cleared; every
//   entry must be written before a render reads it.
// Stall: a finished result waits in the output register while the block
//   keeps accepting beats; a render whose result cannot be loaded holds the
//   input side until the receiver takes the waiting beat.
module attribute_bitmap_video_decode_top
    import abvd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    abvd_in_if.sink    item,
    abvd_out_if.source result
);

    logic                wr_en;
    logic [STORE_AW-1:0] wr_addr;
    logic [7:0]          wr_data;
    logic                rd_en;
    logic [STORE_AW-1:0] rd_addr;
    logic [7:0]          rd_data;
    logic                out_free;
    form_ctrl_t          ctrl;

    // action decode, border/flash state, store address generation
    abvd_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .out_free (out_free),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .ctrl     (ctrl)
    );

    // 6912 bytes used of an 8K single-read-port RAM
    abvd_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // colour expansion and the result register
    abvd_pixel u_pixel (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .rd_data  (rd_data),
        .out_free (out_free),
        .result   (result)
    );

endmodule
